### rtl/gsm_septet_unpacker_from_hex_defines.svh
// Assertion macros used by the septet unpacker's output queue.
`ifndef GSM_SEPTET_UNPACKER_FROM_HEX_DEFINES_SVH
`define GSM_SEPTET_UNPACKER_FROM_HEX_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define GSU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never hold outside reset.
`define GSU_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### rtl/gsu_pkg.sv
// Types and constants shared by the septet unpacker modules.
`default_nettype none

package gsu_pkg;

    localparam int SEPTET_BITS = 7;
    localparam int FIFO_DEPTH  = 4;

    typedef logic [SEPTET_BITS-1:0] septet_t;
    typedef logic [1:0]             res_count_t;

    typedef struct packed {
        septet_t septet;
        logic    run_last;
    } result_t;

    // Results produced by one accepted word, oldest first.
    typedef struct packed {
        res_count_t count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

### rtl/gsu_core.sv
// Hex pairing and septet unpacking state with per-word result generation.
`default_nettype none

module gsu_core
    import gsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] hex_char,
    input  wire logic       message_end,
    output push_t           push
);

    logic          nibble_pending_reg, nibble_pending_next;
    logic [3:0]    high_nibble_reg, high_nibble_next;
    logic [2:0]    octet_phase_reg, octet_phase_next;
    septet_t       carry_bits_reg, carry_bits_next;
    logic [2:0]    carry_count_reg, carry_count_next;

    logic [3:0]    nib;
    logic [7:0]    octet;
    logic [2:0]    k;
    logic          carry_full;
    logic [14:0]   shifted;
    septet_t       main_septet;

    // Map ASCII hex to a nibble; anything else reads as zero.
    always_comb
    begin
        if (hex_char >= 8'h30 && hex_char <= 8'h39)
            nib = hex_char[3:0];
        else if ((hex_char >= 8'h41 && hex_char <= 8'h46) ||
                 (hex_char >= 8'h61 && hex_char <= 8'h66))
            nib = hex_char[3:0] + 4'd9;
        else
            nib = 4'd0;
    end

    always_comb
    begin
        octet       = {high_nibble_reg, nib};
        k           = (octet_phase_reg >= 3'(SEPTET_BITS)) ? 3'd0 : octet_phase_reg;
        carry_full  = (carry_count_reg >= 3'(SEPTET_BITS));
        shifted     = {7'd0, octet} << k;
        main_septet = shifted[SEPTET_BITS-1:0] | (carry_full ? '0 : carry_bits_reg);

        nibble_pending_next = nibble_pending_reg;
        high_nibble_next    = high_nibble_reg;
        octet_phase_next    = octet_phase_reg;
        carry_bits_next     = carry_bits_reg;
        carry_count_next    = carry_count_reg;
        push                = '0;

        if (accept)
        begin
            if (!nibble_pending_reg)
            begin
                high_nibble_next    = nib;
                nibble_pending_next = 1'b1;
            end
            else
            begin
                nibble_pending_next = 1'b0;
                high_nibble_next    = 4'd0;
                if (carry_full)
                begin
                    push.count  = 2'd2;
                    push.first  = '{septet: carry_bits_reg, run_last: 1'b0};
                    push.second = '{septet: main_septet, run_last: 1'b1};
                end
                else
                begin
                    push.count = 2'd1;
                    push.first = '{septet: main_septet, run_last: 1'b1};
                end
                carry_bits_next  = septet_t'(octet >> (3'(SEPTET_BITS) - k));
                carry_count_next = k + 3'd1;
                octet_phase_next = (k == 3'(SEPTET_BITS - 1)) ? 3'd0 : k + 3'd1;
            end

            if (message_end)
            begin
                nibble_pending_next = 1'b0;
                high_nibble_next    = 4'd0;
                octet_phase_next    = 3'd0;
                carry_bits_next     = '0;
                carry_count_next    = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nibble_pending_reg <= 1'b0;
            high_nibble_reg    <= 4'd0;
            octet_phase_reg    <= 3'd0;
            carry_bits_reg     <= '0;
            carry_count_reg    <= 3'd0;
        end
        else
        begin
            nibble_pending_reg <= nibble_pending_next;
            high_nibble_reg    <= high_nibble_next;
            octet_phase_reg    <= octet_phase_next;
            carry_bits_reg     <= carry_bits_next;
            carry_count_reg    <= carry_count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/gsu_out_fifo.sv
// Small result queue that takes up to two septets per cycle and drains one.
`default_nettype none

`include "gsm_septet_unpacker_from_hex_defines.svh"

module gsu_out_fifo
    import gsu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire push_t   push,
    output logic         room,
    output logic         valid,
    input  wire logic    ready,
    output result_t      head
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    result_t            mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    assign valid = (count_reg != '0);
    assign head  = mem[rd_ptr_reg];
    assign pop   = valid && ready;
    // Leave space for the largest burst one word can cause.
    assign room  = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_reg + PTR_W'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `GSU_NEVER(a_no_overflow, clk, rst_n, count_reg > CNT_W'(FIFO_DEPTH), "queue overflow")
    `GSU_NEVER(a_push_needs_room, clk, rst_n, (push.count != 2'd0) && !room, "push without room")
    `GSU_ASSERT(a_count_tracks, clk, rst_n,
        (push.count == 2'd2 && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(2)),
        "count lost a double push")

endmodule

`default_nettype wire

### rtl/gsm_septet_unpacker_from_hex.sv
// Top level of the hex-text to GSM 7-bit septet unpacker.
//
// Input channel: in_valid/in_ready carry one ASCII hex character per word
// (hex_char) plus message_end on the last character of a message. Case is
// ignored; a non-hex character decodes as nibble zero.
// Output channel: out_valid/out_ready carry one septet per word; run_last
// marks the last septet caused by one input word.
// Every second character completes an octet and yields one septet, or two
// when the carry has filled to a whole septet. With the queue empty, a word's
// first septet is visible on the output the cycle after the word is accepted.
// Throughput: one input word per cycle while the receiver takes one septet
// per cycle; a word that yields two septets puts both in the queue at once,
// and the receiver takes them one at a time. The four-entry result queue
// sets this: input is taken whenever at least two entries are free, so a
// receiver stall backs up the queue and then drops in_ready, with no septet lost.
// Reset clears the unpacking state and empties the queue; no clearing pass.
// message_end clears the unpacking state right after its word, so a lone
// high nibble and an unsent full carry are dropped.
`default_nettype none

module gsm_septet_unpacker_from_hex
    import gsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] hex_char,
    input  wire logic       message_end,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [6:0]      septet,
    output logic            run_last
);

    push_t   push;
    result_t head;
    logic    accept;

    // Take a word only when the queue can absorb its worst-case output.
    assign accept = in_valid && in_ready;

    gsu_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .hex_char    (hex_char),
        .message_end (message_end),
        .push        (push)
    );

    gsu_out_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (in_ready),
        .valid (out_valid),
        .ready (out_ready),
        .head  (head)
    );

    assign septet   = head.septet;
    assign run_last = head.run_last;

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the hex-text to GSM 7-bit septet unpacker.
`timescale 1ns / 100ps

module testbench;
    import gsu_pkg::*;

    localparam int HOLD_OFF_CYCLES  = 200;  // long receiver stall to back up the queue
    localparam int HOLD_OFF_AFTER   = 300;  // words accepted before the long stall starts
    localparam int RANDOM_WORDS     = 900;
    localparam int DRAIN_CYCLES     = 32;

    // Track the unpacking state and hold the septets still owed by the block.
    class septet_tracker;
        bit          pending_nib;
        bit [3:0]    held_nib;
        bit [2:0]    phase;
        bit [6:0]    carry;
        bit [2:0]    carry_len;
        result_t     expected_q[$];
        int unsigned words_seen;
        int unsigned errors;

        function new();
            clear();
            words_seen = 0;
            errors     = 0;
        endfunction

        function void clear();
            pending_nib = 1'b0;
            held_nib    = '0;
            phase       = '0;
            carry       = '0;
            carry_len   = '0;
        endfunction

        function bit [3:0] to_nibble(bit [7:0] ch);
            if (ch >= "0" && ch <= "9")
                return 4'(ch - "0");
            if (ch >= "A" && ch <= "F")
                return 4'(ch - "A" + 10);
            if (ch >= "a" && ch <= "f")
                return 4'(ch - "a" + 10);
            return 4'd0;
        endfunction

        // Note one accepted word and queue the septets it must cause.
        function void note_word(bit [7:0] ch, bit last_char);
            bit [3:0]    nib;
            bit [7:0]    octet;
            bit [7:0]    low_mask;
            int unsigned k;
            int          n;
            result_t     res [2];
            nib = to_nibble(ch);
            n   = 0;
            words_seen++;
            if (!pending_nib)
            begin
                held_nib    = nib;
                pending_nib = 1'b1;
            end
            else
            begin
                octet       = {held_nib, nib};
                k           = (phase >= SEPTET_BITS) ? 0 : phase;
                pending_nib = 1'b0;
                held_nib    = '0;
                // Flush a whole carried septet ahead of this octet's septet.
                if (carry_len >= SEPTET_BITS)
                begin
                    res[n].septet   = carry;
                    res[n].run_last = 1'b0;
                    n++;
                    carry     = '0;
                    carry_len = '0;
                end
                low_mask        = (8'd1 << (SEPTET_BITS - k)) - 8'd1;
                res[n].septet   = 7'(((octet & low_mask) << k) | {1'b0, carry});
                res[n].run_last = 1'b0;
                n++;
                carry     = 7'(octet >> (SEPTET_BITS - k));
                carry_len = 3'(k + 1);
                phase     = 3'((k + 1) % SEPTET_BITS);
            end
            if (n > 0)
                res[n-1].run_last = 1'b1;
            for (int i = 0; i < n; i++)
                expected_q.insert(expected_q.size(), res[i]);
            if (last_char)
                clear();
        endfunction

        // Compare one accepted septet with the oldest one owed.
        function void check_septet(logic [6:0] got_septet, logic got_last);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected septet %0h (run_last %0b) with nothing owed",
                       got_septet, got_last);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got_septet !== want.septet)
            begin
                $error("septet mismatch: expected %0h, actual %0h", want.septet, got_septet);
                errors++;
            end
            if (got_last !== want.run_last)
            begin
                $error("run_last mismatch: expected %0b, actual %0b", want.run_last, got_last);
                errors++;
            end
        endfunction

        function int owed();
            return expected_q.size();
        endfunction
    endclass

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] hex_char    = 8'h00;
    logic       message_end = 1'b0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [6:0] septet;
    logic       run_last;

    septet_tracker tracker;
    int            burst_left = 0;
    int            words_sent = 0;

    gsm_septet_unpacker_from_hex u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .hex_char    (hex_char),
        .message_end (message_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .septet      (septet),
        .run_last    (run_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offer one word and hold it until accepted; open a random gap between bursts.
    task automatic send_word(input logic [7:0] ch, input logic last_char);
        int gap;
        if (burst_left == 0)
        begin
            // Some bursts follow back to back so long stretches see no idling.
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid    <= 1'b1;
        hex_char    <= ch;
        message_end <= last_char;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_word(ch, last_char);
        burst_left--;
        words_sent++;
    endtask

    // Draw one character: mostly hex in either case, sometimes any byte.
    function automatic logic [7:0] pick_char();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel <= 2)
            return 8'("0" + $urandom_range(0, 9));
        if (sel <= 4)
            return 8'("A" + $urandom_range(0, 5));
        if (sel <= 6)
            return 8'("a" + $urandom_range(0, 5));
        return 8'($urandom_range(0, 255));
    endfunction

    // Send one message of random length, message_end on its last character.
    task automatic send_message();
        int len;
        // Favor whole octets; an odd length leaves a lone nibble to drop.
        if ($urandom_range(0, 9) < 7)
            len = 2 * $urandom_range(1, 20);
        else
            len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++)
            send_word(pick_char(), (i == len - 1));
    endtask

    // Check every septet taken by the receiver.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_septet(septet, run_last);
    end

    // Receiver: stall in stretches of changing pattern, plus one long hold-off.
    initial
    begin
        int  mode;
        int  stretch_left;
        int  tick;
        bit  hold_done;
        mode         = 0;
        stretch_left = 0;
        tick         = 0;
        hold_done    = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!hold_done && tracker.words_seen >= HOLD_OFF_AFTER)
            begin
                // Hold off long enough to fill the queue and drop in_ready.
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            if (stretch_left == 0)
            begin
                mode         = $urandom_range(0, 3);
                stretch_left = $urandom_range(8, 60);
            end
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= (tick % 4 == 0);
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
            stretch_left--;
            tick++;
            @(posedge clk);
        end
    end

    // Main sequence: reset, directed messages, random messages, drain.
    initial
    begin
        string      msg_whole;
        logic [7:0] msg_odd [15];
        tracker = new();
        // Eight octets: the carry fills after seven and goes out ahead of the eighth.
        msg_whole = "FF00ffA5a912EdCb";
        // Seven octets then a lone nibble: full carry and high nibble both dropped.
        // Range edges of hex and non-hex characters, zero and all-ones bytes included.
        msg_odd = '{8'h3A, 8'h2F, 8'h40, 8'h47, 8'h60, 8'h67, 8'h00, 8'hFF,
                    8'h39, 8'h30, 8'h46, 8'h41, 8'h66, 8'h61, 8'h37};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < msg_whole.len(); i++)
            send_word(msg_whole[i], (i == msg_whole.len() - 1));
        for (int i = 0; i < 15; i++)
            send_word(msg_odd[i], (i == 14));

        while (words_sent < RANDOM_WORDS + 31)
            send_message();
        in_valid <= 1'b0;

        while (tracker.owed() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Stop a hung run; far beyond the slowest legal schedule.
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
